// ===== src/sjfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfe_pkg
// Types and constants shared by the servo jog frame encoder modules.
// ----------------------------------------------------------------------------
package sjfe_pkg;

  localparam int unsigned FRAME_LEN = 12;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

  localparam logic [7:0]  HEADER_BYTE     = 8'hFF;
  localparam logic [7:0]  FRAME_SIZE_BYTE = 8'h0C;
  localparam logic [7:0]  CHECK_MASK      = 8'hFE;
  localparam logic [7:0]  CMD_RESET       = 8'd6;
  localparam logic [11:0] MAX_PLAY_MS     = 12'd2856;

  // floor(y / 7) as (y * RECIP_7) >> RECIP_SHIFT, exact for y up to 1785
  localparam logic [11:0] RECIP_7     = 12'd2341;
  localparam int unsigned RECIP_SHIFT = 14;

  localparam logic [2:0] LED_GREEN = 3'd1;
  localparam logic [2:0] LED_BLUE  = 3'd2;
  localparam logic [2:0] LED_RED   = 3'd3;

  localparam logic [7:0] SET_GREEN = 8'h04;
  localparam logic [7:0] SET_BLUE  = 8'h08;
  localparam logic [7:0] SET_RED   = 8'h10;
  localparam logic [7:0] SET_NONE  = 8'h00;

  typedef struct packed {
    logic               speed_mode;
    logic [7:0]         servo_id;
    logic signed [11:0] goal;
    logic [11:0]        play_time_ms;
    logic [2:0]         led_colour;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } res_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

endpackage

// ===== src/sjfe_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfe_encoder
// Builds the twelve frame bytes of one jog request and flags rejected ones.
// ----------------------------------------------------------------------------
module sjfe_encoder (
  input  sjfe_pkg::req_t   req,
  input  logic [7:0]       cmd,
  output sjfe_pkg::frame_t frame,
  output logic             ok
);

  logic        neg;
  logic [11:0] mag;
  logic [14:0] ms5;
  logic [11:0] ms5_div8;
  logic [23:0] prod;
  logic [7:0]  play;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [7:0]  led_set;
  logic [7:0]  set_byte;
  logic [7:0]  ck1;
  logic [7:0]  ck2;

  // speed goals go out as magnitude, sign in bit 14 of the goal word
  assign neg = req.speed_mode & req.goal[11];
  assign mag = neg ? (~req.goal + 12'd1) : req.goal;

  assign ok = (req.play_time_ms <= sjfe_pkg::MAX_PLAY_MS) &&
              (mag[11:10] == 2'b00) &&
              (req.speed_mode || !req.goal[11]);

  // play = floor(ms * 5 / 56) = floor(floor(ms * 5 / 8) / 7)
  assign ms5      = {1'b0, req.play_time_ms, 2'b00} + {3'b000, req.play_time_ms};
  assign ms5_div8 = ms5[14:3];
  assign prod     = ms5_div8 * sjfe_pkg::RECIP_7;
  assign play     = prod[sjfe_pkg::RECIP_SHIFT +: 8];

  assign lo = mag[7:0];
  assign hi = {1'b0, neg, 4'b0000, mag[9:8]};

  always_comb begin
    unique case (req.led_colour)
      sjfe_pkg::LED_GREEN: led_set = sjfe_pkg::SET_GREEN;
      sjfe_pkg::LED_BLUE:  led_set = sjfe_pkg::SET_BLUE;
      sjfe_pkg::LED_RED:   led_set = sjfe_pkg::SET_RED;
      default:             led_set = sjfe_pkg::SET_NONE;
    endcase
  end

  assign set_byte = led_set | {6'b000000, req.speed_mode, 1'b0};

  // the id appears twice in the frame and cancels out of the XOR
  assign ck1 = (sjfe_pkg::FRAME_SIZE_BYTE ^ cmd ^ play ^ lo ^ hi ^ set_byte) &
               sjfe_pkg::CHECK_MASK;
  assign ck2 = ~ck1 & sjfe_pkg::CHECK_MASK;

  always_comb begin
    frame[0]  = sjfe_pkg::HEADER_BYTE;
    frame[1]  = sjfe_pkg::HEADER_BYTE;
    frame[2]  = sjfe_pkg::FRAME_SIZE_BYTE;
    frame[3]  = req.servo_id;
    frame[4]  = cmd;
    frame[5]  = ck1;
    frame[6]  = ck2;
    frame[7]  = play;
    frame[8]  = lo;
    frame[9]  = hi;
    frame[10] = set_byte;
    frame[11] = req.servo_id;
  end

endmodule

// ===== src/sjfe_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfe_serializer
// Holds one encoded frame and shifts it out one byte per cycle.
// ----------------------------------------------------------------------------
module sjfe_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sjfe_pkg::frame_t frame_in,
  output logic             ready,
  output sjfe_pkg::res_t   res,
  output logic             res_strobe
);

  localparam logic [sjfe_pkg::CNT_W-1:0] LAST_IDX =
    sjfe_pkg::CNT_W'(sjfe_pkg::FRAME_LEN - 1);

  sjfe_pkg::frame_t            frame_q;
  logic                        active;
  logic                        active_next;
  logic [sjfe_pkg::CNT_W-1:0]  cnt;
  logic [sjfe_pkg::CNT_W-1:0]  cnt_next;
  logic                        on_last;

  assign on_last = active && (cnt == LAST_IDX);
  assign ready   = !active || on_last;

  always_comb begin
    active_next = active;
    cnt_next    = cnt;
    if (load) begin
      active_next = 1'b1;
      cnt_next    = '0;
    end else if (on_last) begin
      active_next = 1'b0;
    end else if (active) begin
      cnt_next = cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else begin
      active <= active_next;
      cnt    <= cnt_next;
    end
  end

  // advance: the current byte always sits at the bottom of the shift register
  always_ff @(posedge clk) begin
    if (load) begin
      frame_q <= frame_in;
    end else if (active) begin
      frame_q <= sjfe_pkg::frame_t'({8'h00, frame_q[sjfe_pkg::FRAME_LEN-1:1]});
    end
  end

  assign res_strobe     = active;
  assign res.frame_byte = frame_q[0];
  assign res.last_byte  = on_last;

  a_load_when_ready: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("frame loaded while serializer still busy");

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    on_last && !load |=> !active)
    else $error("serializer kept running past the last byte");

endmodule

// ===== src/servo_jog_frame_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_jog_frame_encoder
// Encodes single-servo jog requests into 12-byte serial command frames.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It is registered,
// encoded in the next cycle and loaded into the frame shift register, whose
// bytes then appear on res one per cycle, each marked by res_strobe for
// exactly one cycle; res.last_byte flags the twelfth. The receiver cannot
// stall: every byte must be taken as it appears. An accepted frame occupies
// the shift register until its last byte is out, and frames stream back to
// back; the next request can be taken while the current frame is still
// shifting out. The first byte appears once the request has passed through
// req_q and been loaded into the frame shift register. A rejected request
// (goal out of range or play time above 2856 ms) produces no bytes and is
// dropped. The command byte register is to be written through cfg_wr_en /
// cfg_wr_data only while idle (not enforced by the block); it resets to 6.
// ----------------------------------------------------------------------------
module servo_jog_frame_encoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sjfe_pkg::req_t req,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data,
  output sjfe_pkg::res_t res,
  output logic           res_strobe
);

  sjfe_pkg::req_t   req_q;
  logic             req_valid;
  logic             req_valid_next;
  logic [7:0]       cmd;
  sjfe_pkg::frame_t frame;
  logic             ok;
  logic             ser_ready;
  logic             load;
  logic             accept;

  sjfe_encoder u_encoder (
    .req   (req_q),
    .cmd   (cmd),
    .frame (frame),
    .ok    (ok)
  );

  sjfe_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .frame_in   (frame),
    .ready      (ser_ready),
    .res        (res),
    .res_strobe (res_strobe)
  );

  assign load   = req_valid && ok && ser_ready;
  // hold only a good request that waits for the shift register
  assign busy   = req_valid && ok && !ser_ready;
  assign accept = start && !busy;

  always_comb begin
    req_valid_next = req_valid;
    if (accept) begin
      req_valid_next = 1'b1;
    end else if (req_valid && (load || !ok)) begin
      req_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      cmd       <= sjfe_pkg::CMD_RESET;
    end else begin
      req_valid <= req_valid_next;
      if (cfg_wr_en) begin
        cmd <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  a_busy_has_request: assert property (@(posedge clk) disable iff (rst)
    busy |-> req_valid && ok)
    else $error("busy without a pending good request");

  a_load_starts_frame: assert property (@(posedge clk) disable iff (rst)
    load |=> res_strobe && (res.frame_byte == sjfe_pkg::HEADER_BYTE) &&
             !res.last_byte)
    else $error("loaded frame did not start with a header byte");

  a_reject_drops: assert property (@(posedge clk) disable iff (rst)
    req_valid && !ok && !start |=> !req_valid)
    else $error("rejected request was not dropped");

endmodule
